// File: hw/rtl/tlsfp_pkg.sv
package tlsfp_pkg;

  localparam int unsigned HASHED_SUITE_BYTES = 8;

  localparam logic [31:0] FNV_BASIS = 32'h811c9dc5;
  localparam logic [31:0] HASH_MULT = 32'h01000193;

  localparam logic [7:0]  ETYPE_HI      = 8'h08;
  localparam logic [7:0]  ETYPE_LO      = 8'h00;
  localparam logic [7:0]  PROTO_TCP     = 8'd6;
  localparam logic [7:0]  TLS_HANDSHAKE = 8'd22;
  localparam logic [7:0]  HS_CLIENT_HELLO = 8'd1;
  localparam logic [7:0]  MAX_SESSION_ID  = 8'd32;
  localparam logic [5:0]  MIN_HDR_LEN     = 6'd20;
  localparam logic [15:0] DEST_PORT_RESET = 16'd443;

  localparam int unsigned OUT_DATA_W = 128;

  typedef struct packed {
    logic        matched;
    logic [31:0] fingerprint;
    logic [15:0] hello_version;
    logic [14:0] suite_count;
    logic [31:0] source_addr;
    logic [31:0] dest_addr;
  } result_t;

  function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return x * HASH_MULT;
  endfunction

endpackage

// File: hw/rtl/tlsfp_parse.sv
module tlsfp_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              frame_end,
  input  logic [15:0]       dest_port,
  output tlsfp_pkg::result_t res
);
  import tlsfp_pkg::*;

  logic [15:0] byte_offset_r, byte_offset_nxt;
  logic [5:0]  ip_len_r, ip_len_nxt;
  logic [5:0]  tcp_len_r, tcp_len_nxt;
  logic [5:0]  sid_len_r, sid_len_nxt;
  logic [15:0] list_len_r, list_len_nxt;
  logic [15:0] after_len_r, after_len_nxt;
  logic [31:0] hash_r, hash_nxt;
  logic [15:0] version_r, version_nxt;
  logic [31:0] src_r, src_nxt;
  logic [31:0] dst_r, dst_nxt;
  logic        rejected_r, rejected_nxt;

  logic [15:0] off, tcp_at, tls_at, len_at, len_end;
  logic [31:0] hash_in;
  logic [15:0] clamped;

  assign off     = byte_offset_r;
  assign tcp_at  = 16'd14 + {10'd0, ip_len_r};
  assign tls_at  = tcp_at + {10'd0, tcp_len_r};
  assign len_at  = tls_at + 16'd44 + {10'd0, sid_len_r};
  assign hash_in = hash_step(hash_r, data_byte);

  // Walk the frame: the first position that matches decides what this byte does.
  always_comb begin
    ip_len_nxt    = ip_len_r;
    tcp_len_nxt   = tcp_len_r;
    sid_len_nxt   = sid_len_r;
    list_len_nxt  = list_len_r;
    after_len_nxt = after_len_r;
    hash_nxt      = hash_r;
    version_nxt   = version_r;
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    rejected_nxt  = rejected_r;
    if (!rejected_r) begin
      priority if (off == 16'd12 && data_byte != ETYPE_HI) begin
        rejected_nxt = 1'b1;
      end else if (off == 16'd13 && data_byte != ETYPE_LO) begin
        rejected_nxt = 1'b1;
      end else if (off == 16'd14) begin
        ip_len_nxt = {data_byte[3:0], 2'b00};
        rejected_nxt = ({data_byte[3:0], 2'b00} < MIN_HDR_LEN);
      end else if (off == 16'd23 && data_byte != PROTO_TCP) begin
        rejected_nxt = 1'b1;
      end else if (off >= 16'd26 && off <= 16'd29) begin
        src_nxt = {src_r[23:0], data_byte};
      end else if (off >= 16'd30 && off <= 16'd33) begin
        dst_nxt = {dst_r[23:0], data_byte};
      end else if (off <= 16'd14) begin
      end else if (off == tcp_at + 16'd2 && data_byte != dest_port[15:8]) begin
        rejected_nxt = 1'b1;
      end else if (off == tcp_at + 16'd3 && data_byte != dest_port[7:0]) begin
        rejected_nxt = 1'b1;
      end else if (off == tcp_at + 16'd12) begin
        tcp_len_nxt = {data_byte[7:4], 2'b00};
        rejected_nxt = ({data_byte[7:4], 2'b00} < MIN_HDR_LEN);
      end else if (off <= tcp_at + 16'd12) begin
      end else if (off == tls_at && data_byte != TLS_HANDSHAKE) begin
        rejected_nxt = 1'b1;
      end else if (off == tls_at + 16'd5 && data_byte != HS_CLIENT_HELLO) begin
        rejected_nxt = 1'b1;
      end else if (off == tls_at + 16'd9 || off == tls_at + 16'd10) begin
        version_nxt = {version_r[7:0], data_byte};
        hash_nxt    = hash_in;
      end else if (off == tls_at + 16'd43) begin
        if (data_byte > MAX_SESSION_ID) begin
          rejected_nxt = 1'b1;
        end else begin
          sid_len_nxt = data_byte[5:0];
        end
      end else if (off <= tls_at + 16'd43) begin
      end else if (off == len_at || off == len_at + 16'd1) begin
        list_len_nxt = {list_len_r[7:0], data_byte};
      end else if (off > len_at + 16'd1) begin
        if (after_len_r < 16'(HASHED_SUITE_BYTES) && after_len_r < list_len_r) begin
          hash_nxt = hash_in;
        end
        if (after_len_r != 16'hffff) begin
          after_len_nxt = after_len_r + 16'd1;
        end
      end else begin
        // Session id bytes carry nothing the fingerprint needs.
      end
    end
  end

  assign byte_offset_nxt = (byte_offset_r == 16'hffff) ? byte_offset_r : byte_offset_r + 16'd1;

  // The frame counts as matched once the second list-length byte has been seen.
  assign len_end = 16'd58 + {10'd0, ip_len_nxt} + {10'd0, tcp_len_nxt} + {10'd0, sid_len_nxt};
  assign clamped = (list_len_nxt < after_len_nxt) ? list_len_nxt : after_len_nxt;

  always_comb begin
    res = '0;
    if (!rejected_nxt && off > len_end) begin
      res.matched       = 1'b1;
      res.fingerprint   = hash_nxt;
      res.hello_version = version_nxt;
      res.suite_count   = clamped[15:1];
      res.source_addr   = src_nxt;
      res.dest_addr     = dst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && frame_end)) begin
      byte_offset_r <= '0;
      ip_len_r      <= '0;
      tcp_len_r     <= '0;
      sid_len_r     <= '0;
      list_len_r    <= '0;
      after_len_r   <= '0;
      hash_r        <= FNV_BASIS;
      version_r     <= '0;
      src_r         <= '0;
      dst_r         <= '0;
      rejected_r    <= 1'b0;
    end else if (step) begin
      byte_offset_r <= byte_offset_nxt;
      ip_len_r      <= ip_len_nxt;
      tcp_len_r     <= tcp_len_nxt;
      sid_len_r     <= sid_len_nxt;
      list_len_r    <= list_len_nxt;
      after_len_r   <= after_len_nxt;
      hash_r        <= hash_nxt;
      version_r     <= version_nxt;
      src_r         <= src_nxt;
      dst_r         <= dst_nxt;
      rejected_r    <= rejected_nxt;
    end
  end

endmodule

// File: hw/rtl/tls_client_hello_fingerprint.sv
// TLS ClientHello fingerprint. Frame bytes stream in one per request, starting at the
// Ethernet destination address, with in_tlast on the final byte. The block checks for
// untagged IPv4 carrying TCP to the port held in the configuration register (443 after
// reset) and a TLS handshake record with a ClientHello, and keeps a 32-bit FNV-1a hash
// over the client version and the first eight cipher-suite bytes. Exactly one result
// request leaves per frame, after its last byte; when out_tuser (matched) is low every
// data field is zero. The block takes one byte every clock cycle, as the per-byte parse
// and hash update is a single registered step; while a result waits on out_tready the
// next frame's bytes keep flowing, but a second frame end waits behind it. out_tvalid
// rises as the final byte moves from the input register to the result register.
// Write cfg_wr_data with cfg_wr_en only while no frame is in flight.
module tls_client_hello_fingerprint (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [7:0]                           in_tdata,   // data_byte[7:0]
  input  logic                                 in_tlast,   // frame_end
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // fingerprint[31:0], hello_version[47:32], suite_count[62:48],
  // source_addr[94:63], dest_addr[126:95], bit 127 zero
  output logic [tlsfp_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                 out_tuser,  // matched
  input  logic                                 cfg_wr_en,
  input  logic [15:0]                          cfg_wr_data // dest_port
);
  import tlsfp_pkg::*;

  logic [15:0] dest_port_r;
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_end_r;
  logic        out_valid_r;
  result_t     out_res_r;
  result_t     res;
  logic        out_free;
  logic        advance;

  // A byte in the input register moves on unless it ends a frame and the
  // result register is still occupied.
  assign out_free  = !out_valid_r || out_tready;
  assign advance   = s1_valid_r && (!s1_end_r || out_free);
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_port_r <= DEST_PORT_RESET;
    end else if (cfg_wr_en) begin
      dest_port_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
      s1_end_r  <= in_tlast;
    end
  end

  tlsfp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .data_byte (s1_byte_r),
    .frame_end (s1_end_r),
    .dest_port (dest_port_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && s1_end_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_end_r) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.matched;
  assign out_tdata  = {1'b0, out_res_r.dest_addr, out_res_r.source_addr,
                       out_res_r.suite_count, out_res_r.hello_version,
                       out_res_r.fingerprint};

endmodule

// File: hw/rtl/tlsfp_checker.sv
module tlsfp_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [tlsfp_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                             out_tuser
);
  import tlsfp_pkg::*;

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // An unmatched frame reports all-zero fields.
  a_unmatched_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("unmatched result carries data");

  // Reset empties the result register.
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Reset empties the input register, so the block is ready right after.
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("not ready after reset");

endmodule

bind tls_client_hello_fingerprint tlsfp_checker u_chk (.*);
